// ===== design/glla_pkg.sv =====
// Package with the shared constants and types of the least-loaded assigner.
`timescale 1ns / 1ps

package glla_pkg;

  localparam int MAX_VEHICLES = 16;
  localparam int IDX_W        = $clog2(MAX_VEHICLES);
  localparam int COUNT_W      = 5;
  localparam int CMP_W        = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int LOAD_W       = 32;
  localparam int COST_W       = 24;
  localparam int TAG_W        = 32;
  localparam int VIDX_W       = 4;
  localparam int S_DATA_W     = 88;
  localparam int M_DATA_W     = 128;

  typedef struct packed {
    logic              valid;
    logic [LOAD_W-1:0] min_load;
    logic [IDX_W-1:0]  min_idx;
    logic [LOAD_W-1:0] max_load;
  } scan_tok_t;

  typedef struct packed {
    logic              clear;
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [LOAD_W-1:0] value;
  } load_upd_t;

endpackage

// ===== design/glla_cell.sv =====
// One vehicle cell: holds a load and folds it into the passing scan token.
`timescale 1ns / 1ps

module glla_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [glla_pkg::IDX_W-1:0]    cell_idx,
  input  logic [glla_pkg::COUNT_W-1:0]  count,
  input  glla_pkg::load_upd_t           upd,
  input  glla_pkg::scan_tok_t           tok_in,
  output glla_pkg::scan_tok_t           tok_out
);

  logic [glla_pkg::LOAD_W-1:0] load;
  logic                        active;
  glla_pkg::scan_tok_t         tok_next;

  assign active = (cell_idx == '0) ||
                  (glla_pkg::CMP_W'(cell_idx) < glla_pkg::CMP_W'(count));

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && active) begin
      if (load < tok_in.min_load) begin
        tok_next.min_load = load;
        tok_next.min_idx  = cell_idx;
      end
      if (load > tok_in.max_load) begin
        tok_next.max_load = load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load    <= '0;
      tok_out <= '0;
    end else begin
      if (upd.clear) begin
        load <= '0;
      end else if (upd.en && (upd.idx == cell_idx)) begin
        load <= upd.value;
      end
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/greedy_least_loaded_assigner.sv =====
// Top level of the greedy least-loaded mission assigner.
`timescale 1ns / 1ps

// Each mission beat goes to the least-loaded vehicle among the first vehicle_count vehicles
// (at least one; lowest index on ties), and its cost is added to that load, saturating at all
// ones. The loads live in a row of MAX_VEHICLES cells; a scan token walks the row one cell per
// cycle, collecting the smallest and largest load. One mission is handled at a time, and the
// next is accepted only once the walk along the row is done and the result has been registered.
// The input side accepts the next mission while a result still waits in the output register.
// A tuser of 1 clears all loads first; on a tlast mission the result carries the makespan.
module greedy_least_loaded_assigner (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [glla_pkg::COUNT_W-1:0]    cfg_data,   // vehicle_count
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [glla_pkg::S_DATA_W-1:0]   s_tdata,    // mission_cost, start_tag, end_tag
  input  logic                            s_tuser,    // first_of_problem
  input  logic                            s_tlast,    // last_of_problem
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [glla_pkg::M_DATA_W-1:0]   m_tdata,    // vehicle_index, cost_out, start_out,
                                                      // end_out, makespan, zero fill
  output logic                            m_tlast     // is_last
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t                        state;
  logic [glla_pkg::COUNT_W-1:0]  count;
  logic                          launch;
  logic [glla_pkg::COST_W-1:0]   cost;
  logic [glla_pkg::TAG_W-1:0]    start_tag;
  logic [glla_pkg::TAG_W-1:0]    end_tag;
  logic                          last;
  logic [glla_pkg::IDX_W-1:0]    best_idx;
  logic [glla_pkg::LOAD_W-1:0]   new_load;
  logic [glla_pkg::LOAD_W-1:0]   max_load;
  logic [glla_pkg::LOAD_W:0]     sum;
  logic [glla_pkg::LOAD_W-1:0]   sat_sum;
  logic [glla_pkg::LOAD_W-1:0]   span;
  logic                          s_accept;
  logic                          out_free;
  glla_pkg::load_upd_t           upd;
  glla_pkg::scan_tok_t           tok [glla_pkg::MAX_VEHICLES+1];
  glla_pkg::scan_tok_t           tok_end;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign tok[0] = '{valid: launch, min_load: '1, min_idx: '0, max_load: '0};
  assign tok_end = tok[glla_pkg::MAX_VEHICLES];

  assign sum     = {1'b0, tok_end.min_load} + (glla_pkg::LOAD_W+1)'(cost);
  assign sat_sum = sum[glla_pkg::LOAD_W] ? '1 : sum[glla_pkg::LOAD_W-1:0];
  assign span    = (new_load > max_load) ? new_load : max_load;

  always_comb begin
    upd.clear = s_accept && s_tuser;
    upd.en    = (state == FINISH) && out_free;
    upd.idx   = best_idx;
    upd.value = new_load;
  end

  for (genvar i = 0; i < glla_pkg::MAX_VEHICLES; i++) begin : g_cell
    glla_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (glla_pkg::IDX_W'(i)),
      .count    (count),
      .upd      (upd),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= glla_pkg::COUNT_W'(1);
      launch   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      launch <= s_accept;
      if (cfg_valid && cfg_ready) begin
        count <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_accept) begin
            cost      <= s_tdata[23:0];
            start_tag <= s_tdata[55:24];
            end_tag   <= s_tdata[87:56];
            last      <= s_tlast;
            state     <= SCAN;
          end
        end
        SCAN: begin
          if (tok_end.valid) begin
            best_idx <= tok_end.min_idx;
            new_load <= sat_sum;
            max_load <= tok_end.max_load;
            state    <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tvalid         <= 1'b1;
            m_tlast          <= last;
            m_tdata[3:0]     <= glla_pkg::VIDX_W'(best_idx);
            m_tdata[27:4]    <= cost;
            m_tdata[59:28]   <= start_tag;
            m_tdata[91:60]   <= end_tag;
            m_tdata[123:92]  <= last ? span : '0;
            m_tdata[127:124] <= '0;
            state            <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/glla_checker.sv =====
// Port-level checker for the assigner, bound to the top level.
`timescale 1ns / 1ps

module glla_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [glla_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tlast
);

  // An output beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  // The block works on one mission at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // Makespan is only reported on the last mission of a problem.
  a_span_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[123:92] == '0)
    else $error("makespan nonzero on a non-last result");

  // The fill bits above the packed fields stay zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[127:124] == '0)
    else $error("output fill bits not zero");

endmodule

bind greedy_least_loaded_assigner glla_checker u_glla_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the greedy least-loaded mission assigner.
`timescale 1ns / 1ps

module tb;
  import glla_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = MAX_VEHICLES + 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    logic [VIDX_W-1:0] vehicle;
    logic [COST_W-1:0] cost;
    logic [TAG_W-1:0]  start_tag;
    logic [TAG_W-1:0]  end_tag;
    logic              last;
    logic [LOAD_W-1:0] makespan;
  } assignment_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;
  logic                 s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tlast;

  logic [LOAD_W-1:0]    fleet_load [MAX_VEHICLES];
  logic [COUNT_W-1:0]   fleet_size;
  assignment_t          pending_assignments [$];
  int                   errors;
  int                   send_idle;
  int                   recv_idle;
  int                   hold_req;
  int                   hold_seen;
  int                   hold_left;
  int                   stall_cycles;

  greedy_least_loaded_assigner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic assignment_t assign_mission(input logic [COST_W-1:0] cost,
                                                 input logic [TAG_W-1:0] start_tag,
                                                 input logic [TAG_W-1:0] end_tag,
                                                 input logic first, input logic last);
    assignment_t       a;
    int                n;
    int                best;
    logic [LOAD_W:0]   sum;
    logic [LOAD_W-1:0] span;
    n = fleet_size;
    if (n == 0) n = 1;
    if (n > MAX_VEHICLES) n = MAX_VEHICLES;
    if (first) begin
      for (int i = 0; i < MAX_VEHICLES; i++) fleet_load[i] = '0;
    end
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (fleet_load[i] < fleet_load[best]) best = i;
    end
    sum = {1'b0, fleet_load[best]} + {{(LOAD_W + 1 - COST_W){1'b0}}, cost};
    fleet_load[best] = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
    span = '0;
    if (last) begin
      for (int i = 0; i < n; i++) begin
        if (fleet_load[i] > span) span = fleet_load[i];
      end
    end
    a.vehicle   = best[VIDX_W-1:0];
    a.cost      = cost;
    a.start_tag = start_tag;
    a.end_tag   = end_tag;
    a.last      = last;
    a.makespan  = span;
    return a;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic logic [COST_W-1:0] rand_cost();
    case ($urandom_range(9))
      0: return '0;
      1: return {COST_W{1'b1}};
      2, 3: return COST_W'($urandom_range(15));
      4: return COST_W'($urandom_range(4095));
      default: return COST_W'($urandom());
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    case ($urandom_range(15))
      0: return '0;
      1: return {TAG_W{1'b1}};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] rand_fleet_size();
    case ($urandom_range(9))
      0: return '0;
      1: return COUNT_W'($urandom_range(MAX_VEHICLES + 1, 31));
      2: return COUNT_W'(MAX_VEHICLES);
      3: return COUNT_W'(1);
      default: return COUNT_W'($urandom_range(2, MAX_VEHICLES - 1));
    endcase
  endfunction

  task automatic send_mission(input logic [COST_W-1:0] cost, input logic [TAG_W-1:0] start_tag,
                              input logic [TAG_W-1:0] end_tag, input logic first,
                              input logic last);
    assignment_t expected;
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {end_tag, start_tag, cost};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected = assign_mission(cost, start_tag, end_tag, first, last);
    pending_assignments = {pending_assignments, expected};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fleet_size(input logic [COUNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    fleet_size  = value;
  endtask

  task automatic test_reset_default();
    send_mission('0, '0, '0, 1'b0, 1'b0);
    send_mission({COST_W{1'b1}}, {TAG_W{1'b1}}, {TAG_W{1'b1}}, 1'b0, 1'b1);
  endtask

  task automatic test_zero_fleet();
    write_fleet_size('0);
    send_mission(24'd5, rand_tag(), rand_tag(), 1'b1, 1'b0);
    send_mission(24'd7, rand_tag(), rand_tag(), 1'b0, 1'b1);
  endtask

  task automatic test_ties_and_choice();
    write_fleet_size(5'd4);
    for (int k = 0; k < 4; k++) send_mission(24'd10, rand_tag(), rand_tag(), k == 0, 1'b0);
    send_mission(24'd5, rand_tag(), rand_tag(), 1'b0, 1'b0);
    send_mission(24'd3, rand_tag(), rand_tag(), 1'b0, 1'b1);
  endtask

  task automatic test_fleet_clamp_and_change();
    write_fleet_size(5'd31);
    send_mission(24'h000300, rand_tag(), rand_tag(), 1'b1, 1'b0);
    send_mission(24'h000200, rand_tag(), rand_tag(), 1'b0, 1'b0);
    send_mission(24'h000100, rand_tag(), rand_tag(), 1'b0, 1'b1);
    // Shrinking the fleet without a new problem keeps the loads.
    write_fleet_size(5'd2);
    send_mission(24'h000050, rand_tag(), rand_tag(), 1'b0, 1'b1);
    write_fleet_size(5'd16);
    send_mission('0, rand_tag(), rand_tag(), 1'b1, 1'b1);
  endtask

  task automatic test_load_saturation();
    write_fleet_size(5'd1);
    for (int k = 0; k < 300; k++) begin
      send_mission((k % 37 == 5) ? rand_cost() : {COST_W{1'b1}}, rand_tag(), rand_tag(),
                   k == 0, (k % 50 == 49) || (k == 299));
    end
  endtask

  task automatic test_random_problems(input int items);
    int   sent;
    int   len;
    logic first;
    logic last;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(3) == 0) write_fleet_size(rand_fleet_size());
      len = ($urandom_range(7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      for (int k = 0; k < len; k++) begin
        first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        last  = (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        send_mission(rand_cost(), rand_tag(), rand_tag(), first, last);
        sent++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    int saved_idle;
    saved_idle = send_idle;
    write_fleet_size(COUNT_W'($urandom_range(2, MAX_VEHICLES)));
    send_idle <= 0;
    hold_req  <= hold_req + 1;
    for (int k = 0; k < 40; k++) send_mission(rand_cost(), rand_tag(), rand_tag(), k == 0, k == 39);
    send_idle <= saved_idle;
  endtask

  always @(posedge clk) begin
    assignment_t exp_a;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_assignments.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          exp_a = pending_assignments.pop_front();
          check_field("vehicle_index", 64'(exp_a.vehicle), 64'(m_tdata[3:0]));
          check_field("cost_out", 64'(exp_a.cost), 64'(m_tdata[27:4]));
          check_field("start_out", 64'(exp_a.start_tag), 64'(m_tdata[59:28]));
          check_field("end_out", 64'(exp_a.end_tag), 64'(m_tdata[91:60]));
          check_field("makespan", 64'(exp_a.makespan), 64'(m_tdata[123:92]));
          check_field("is_last", 64'(exp_a.last), 64'(m_tlast));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= 1'b0;
    s_tlast      <= 1'b0;
    hold_req     <= 0;
    send_idle    <= 36;
    recv_idle    <= 77;
    fleet_size    = COUNT_W'(1);
    for (int i = 0; i < MAX_VEHICLES; i++) fleet_load[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default();
    test_zero_fleet();
    test_ties_and_choice();
    test_fleet_clamp_and_change();
    test_load_saturation();
    test_random_problems(280);
    test_output_backpressure();

    drain();
    send_idle <= 77;
    recv_idle <= 36;
    test_random_problems(300);

    drain();
    send_idle <= 0;
    recv_idle <= 0;
    test_random_problems(300);

    drain();
    if (errors == 0 && pending_assignments.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/glla_pkg.sv
design/glla_cell.sv
design/greedy_least_loaded_assigner.sv
design/glla_checker.sv
sim/tb.sv
